@@ rtl/wfe_pkg.sv @@
// ----------------------------------------------------------------------------
// wfe_pkg: shared types and constants of the wall-follow error unit
// Item types, register codes and fixed-point constants used by every file.
// ----------------------------------------------------------------------------
package wfe_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FIELD_BITS  = 12;
    localparam int CFG_BITS    = 24;
    localparam int CW          = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
    localparam int EW          = CW + 8;

    // 20 * limit, the numerator of limit / 0.7 scaled by two.
    localparam int B_W         = FIELD_BITS + 5;
    localparam int Q_W         = B_W - 2;
    // floor(b / 7) == (b * RECIP) >> RECIP_SH, exact for every b below 2**B_W.
    localparam int RECIP_W     = 18;
    localparam int RECIP_SH    = 20;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(149797);
    localparam int PROD_W      = B_W + RECIP_W;

    localparam int Q_AW        = 1;
    localparam int Q_DEPTH     = 1 << Q_AW;

    localparam logic signed [EW-1:0] K2      = EW'(2);
    localparam logic signed [EW-1:0] K7      = EW'(7);
    localparam logic signed [EW-1:0] K10     = EW'(10);
    localparam logic signed [EW-1:0] SAT_MAX = EW'(32767);
    localparam logic signed [EW-1:0] SAT_MIN = -SAT_MAX - EW'(1);

    localparam logic [1:0] SENSOR_RF = 2'd0;
    localparam logic [1:0] SENSOR_LF = 2'd1;
    localparam logic [1:0] SENSOR_RS = 2'd2;
    localparam logic [1:0] SENSOR_LS = 2'd3;

    localparam logic KIND_SAMPLE = 1'b0;

    localparam logic [2:0] CFG_SIDE_REFS     = 3'd0;
    localparam logic [2:0] CFG_SIDE_LIMITS   = 3'd1;
    localparam logic [2:0] CFG_FRONT_REFS    = 3'd2;
    localparam logic [2:0] CFG_FRONT_LIMITS  = 3'd3;
    localparam logic [2:0] CFG_FRONT_CTRL    = 3'd4;
    localparam logic [2:0] CFG_FRONT_NOCTRL  = 3'd5;
    localparam logic [2:0] CFG_EDGE_STEP     = 3'd6;
    localparam logic [2:0] CFG_EDGE_MARGIN   = 3'd7;

    typedef enum logic [1:0] {
        CORR_NONE  = 2'b00,
        CORR_LEFT  = 2'b01,
        CORR_RIGHT = 2'b10
    } corr_t;

    typedef struct packed {
        logic                   kind;
        logic [1:0]             sensor;
        logic [SAMPLE_BITS-1:0] dark_sample;
        logic [SAMPLE_BITS-1:0] lit_sample;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] steer_error;
        logic               wall_ahead;
        logic               wall_right;
        logic               wall_left;
    } result_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]   side_refs;
        logic [CFG_BITS-1:0]   side_limits;
        logic [CFG_BITS-1:0]   front_refs;
        logic [CFG_BITS-1:0]   front_limits;
        logic [CFG_BITS-1:0]   front_ctrl_levels;
        logic [CFG_BITS-1:0]   front_noctrl_levels;
        logic [FIELD_BITS-1:0] edge_step_limit;
        logic [FIELD_BITS-1:0] edge_ref_margin;
    } cfg_t;

    // Readings after one item plus the wall-edge classification of each side.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rf;
        logic [SAMPLE_BITS-1:0] lf;
        logic [SAMPLE_BITS-1:0] rs;
        logic [SAMPLE_BITS-1:0] ls;
        logic                   edge_r;
        logic                   edge_l;
    } snap_t;

    function automatic logic signed [EW-1:0] ext_f(logic [FIELD_BITS-1:0] v);
        return $signed({{(EW-FIELD_BITS){1'b0}}, v});
    endfunction

    function automatic logic signed [EW-1:0] ext_s(logic [SAMPLE_BITS-1:0] v);
        return $signed({{(EW-SAMPLE_BITS){1'b0}}, v});
    endfunction

endpackage

@@ rtl/wall_follow_error_unit.sv @@
// An accepted item is registered in the input queue, the error stage, the
// divide-by-seven stage and the result queue before it reaches the result ports.
// Throughput: one item per cycle while results are popped; intake state is
// updated per item; both stages are fully pipelined between two-entry queues.
// Reset: asynchronous, active low; readings, registers and queues clear at once.
// ----------------------------------------------------------------------------
// wall_follow_error_unit: wall-following steering error
// Stores sensor readings and computes the steering error and wall flags.
// ----------------------------------------------------------------------------
module wall_follow_error_unit
    import wfe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sample_t             sample,
    output logic                empty,
    input  logic                pop,
    output result_t             result,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    cfg_t  cfg_reg;
    snap_t snap_in;
    snap_t snap_out;
    logic  accept;
    logic  q_empty;
    logic  q_pop;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SIDE_REFS:    cfg_reg.side_refs           <= cfg_data;
                CFG_SIDE_LIMITS:  cfg_reg.side_limits         <= cfg_data;
                CFG_FRONT_REFS:   cfg_reg.front_refs          <= cfg_data;
                CFG_FRONT_LIMITS: cfg_reg.front_limits        <= cfg_data;
                CFG_FRONT_CTRL:   cfg_reg.front_ctrl_levels   <= cfg_data;
                CFG_FRONT_NOCTRL: cfg_reg.front_noctrl_levels <= cfg_data;
                CFG_EDGE_STEP:    cfg_reg.edge_step_limit     <= cfg_data[FIELD_BITS-1:0];
                CFG_EDGE_MARGIN:  cfg_reg.edge_ref_margin     <= cfg_data[FIELD_BITS-1:0];
                default:          cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    wfe_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .sample          (sample),
        .edge_step_limit (cfg_reg.edge_step_limit),
        .snap            (snap_in)
    );

    wfe_snap_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (snap_in),
        .full  (full),
        .pop   (q_pop),
        .rdata (snap_out),
        .empty (q_empty)
    );

    wfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .snap       (snap_out),
        .snap_valid (!q_empty),
        .snap_take  (q_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

@@ rtl/wfe_front.sv @@
// ----------------------------------------------------------------------------
// wfe_front: sample intake
// Keeps the latest and prior reading of each sensor and classifies wall edges.
// ----------------------------------------------------------------------------
module wfe_front
    import wfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  sample_t               sample,
    input  logic [FIELD_BITS-1:0] edge_step_limit,
    output snap_t                 snap
);

    logic [SAMPLE_BITS-1:0] latest_reg [4];
    logic [SAMPLE_BITS-1:0] prior_reg  [4];
    logic [SAMPLE_BITS-1:0] latest_next [4];
    logic [SAMPLE_BITS-1:0] prior_next  [4];
    logic [SAMPLE_BITS-1:0] value;
    logic                   is_sample;

    function automatic logic step_big(logic [SAMPLE_BITS-1:0] now_v,
                                      logic [SAMPLE_BITS-1:0] old_v,
                                      logic [FIELD_BITS-1:0]  lim);
        logic [CW:0] mag;
        mag = (now_v >= old_v) ? (CW+1)'(now_v - old_v) : (CW+1)'(old_v - now_v);
        return mag > (CW+1)'(lim);
    endfunction

    assign value     = (sample.lit_sample >= sample.dark_sample)
                     ? sample.lit_sample - sample.dark_sample : '0;
    assign is_sample = accept && (sample.kind == KIND_SAMPLE);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            latest_next[i] = latest_reg[i];
            prior_next[i]  = prior_reg[i];
            if (is_sample && (sample.sensor == 2'(i)))
            begin
                latest_next[i] = value;
                prior_next[i]  = latest_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                latest_reg[i] <= '0;
                prior_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                latest_reg[i] <= latest_next[i];
                prior_reg[i]  <= prior_next[i];
            end
        end
    end

    // The item carries the state as it stands after the item itself.
    always_comb
    begin
        snap.rf     = latest_next[SENSOR_RF];
        snap.lf     = latest_next[SENSOR_LF];
        snap.rs     = latest_next[SENSOR_RS];
        snap.ls     = latest_next[SENSOR_LS];
        snap.edge_r = step_big(latest_next[SENSOR_RS], prior_next[SENSOR_RS],
                               edge_step_limit);
        snap.edge_l = step_big(latest_next[SENSOR_LS], prior_next[SENSOR_LS],
                               edge_step_limit);
    end

endmodule

@@ rtl/wfe_snap_queue.sv @@
// ----------------------------------------------------------------------------
// wfe_snap_queue: queue between intake and error computation
// A short first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
module wfe_snap_queue
    import wfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  snap_t wdata,
    output logic  full,
    input  logic  pop,
    output snap_t rdata,
    output logic  empty
);

    snap_t           mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wptr_reg;
    logic [Q_AW-1:0] rptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
        end
    end

endmodule

@@ rtl/wfe_back.sv @@
// ----------------------------------------------------------------------------
// wfe_back: steering error computation
// Two pipeline stages compute the error and flags; a result queue holds them.
// ----------------------------------------------------------------------------
module wfe_back
    import wfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  snap_t   snap,
    input  logic    snap_valid,
    output logic    snap_take,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    // Stage A: priority error, correction choice and flags.
    logic                    a_valid_reg;
    corr_t                   a_mode_reg;
    logic signed [EW-1:0]    a_val_reg;
    logic [B_W-1:0]          a_b_reg;
    logic [2:0]              a_flags_reg;
    logic                    a_ready;

    // Stage B: quotient of b by seven.
    logic                    b_valid_reg;
    corr_t                   b_mode_reg;
    logic signed [EW-1:0]    b_val_reg;
    logic [B_W-1:0]          b_b_reg;
    logic [Q_W-1:0]          b_q_reg;
    logic [2:0]              b_flags_reg;
    logic                    b_ready;

    logic signed [EW-1:0] rf, lf, rs, ls;
    logic signed [EW-1:0] rs_ref, ls_ref, rf_ref, lf_ref;
    logic signed [EW-1:0] rs_lim, ls_lim, rf_lim, lf_lim;
    logic signed [EW-1:0] th_r, th_l, err0;
    logic                 wall_r, wall_l, corr_l, corr_r;
    corr_t                mode_next;
    logic signed [EW-1:0] val_next;
    logic [FIELD_BITS-1:0] lim_sel;
    logic [B_W-1:0]       b_next;
    logic [2:0]           flags_next;
    logic [PROD_W-1:0]    prod;

    logic [B_W-1:0]       q7;
    logic                 rem_nz;
    logic signed [EW-1:0] b_s, q_s, a7, res, sat;
    result_t              res_item;

    result_t         oq_reg [Q_DEPTH];
    logic [Q_AW-1:0] oq_wptr_reg;
    logic [Q_AW-1:0] oq_rptr_reg;
    logic [Q_AW:0]   oq_count_reg;
    logic            oq_full, oq_push, oq_pop;

    assign oq_full   = (oq_count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty     = (oq_count_reg == '0);
    assign oq_push   = b_valid_reg && !oq_full;
    assign oq_pop    = pop && !empty;
    assign b_ready   = !b_valid_reg || !oq_full;
    assign a_ready   = !a_valid_reg || b_ready;
    assign snap_take = snap_valid && a_ready;

    always_comb
    begin
        rf     = ext_s(snap.rf);
        lf     = ext_s(snap.lf);
        rs     = ext_s(snap.rs);
        ls     = ext_s(snap.ls);
        rs_ref = ext_f(cfg.side_refs[11:0]);
        ls_ref = ext_f(cfg.side_refs[23:12]);
        rs_lim = ext_f(cfg.side_limits[11:0]);
        ls_lim = ext_f(cfg.side_limits[23:12]);
        rf_ref = ext_f(cfg.front_refs[11:0]);
        lf_ref = ext_f(cfg.front_refs[23:12]);
        rf_lim = ext_f(cfg.front_limits[11:0]);
        lf_lim = ext_f(cfg.front_limits[23:12]);

        th_r   = snap.edge_r ? rs_ref + ext_f(cfg.edge_ref_margin) : rs_lim;
        th_l   = snap.edge_l ? ls_ref + ext_f(cfg.edge_ref_margin) : ls_lim;
        wall_r = rs > th_r;
        wall_l = ls > th_l;

        if (rf > ext_f(cfg.front_noctrl_levels[11:0])
            && lf > ext_f(cfg.front_noctrl_levels[23:12]))
        begin
            err0 = '0;
        end
        else if (rf > ext_f(cfg.front_ctrl_levels[11:0])
                 && lf > ext_f(cfg.front_ctrl_levels[23:12]))
        begin
            err0 = (lf - lf_ref) - (rf - rf_ref);
        end
        else if (wall_r && wall_l)
        begin
            err0 = (rs - rs_ref) + (ls_ref - ls);
        end
        else if (wall_r)
        begin
            err0 = K2 * (rs - rs_ref);
        end
        else if (wall_l)
        begin
            err0 = K2 * (ls_ref - ls);
        end
        else
        begin
            err0 = '0;
        end

        corr_l = (K7 * lf > K10 * lf_lim) && (K7 * rf < K10 * rf_lim);
        corr_r = (K7 * rf > K10 * rf_lim) && (K7 * lf < K10 * lf_lim);

        // The corrected sum (7*err +- 14*reading -+ 20*limit) / 7 is split
        // into a whole part in val_next and b = 20*limit, divided later.
        if (corr_l)
        begin
            mode_next = CORR_LEFT;
            val_next  = err0 - K2 * lf;
            lim_sel   = cfg.front_limits[23:12];
        end
        else if (corr_r)
        begin
            mode_next = CORR_RIGHT;
            val_next  = err0 + K2 * rf;
            lim_sel   = cfg.front_limits[11:0];
        end
        else
        begin
            mode_next = CORR_NONE;
            val_next  = err0;
            lim_sel   = '0;
        end
        b_next = B_W'({lim_sel, 4'b0000}) + B_W'({lim_sel, 2'b00});

        flags_next[2] = (rf > rf_lim) || (lf > lf_lim);
        flags_next[1] = rs > rs_lim;
        flags_next[0] = ls > ls_lim;
    end

    assign prod = PROD_W'(a_b_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            a_mode_reg  <= mode_next;
            a_val_reg   <= val_next;
            a_b_reg     <= b_next;
            a_flags_reg <= flags_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_mode_reg  <= a_mode_reg;
            b_val_reg   <= a_val_reg;
            b_b_reg     <= a_b_reg;
            b_q_reg     <= prod[RECIP_SH +: Q_W];
            b_flags_reg <= a_flags_reg;
        end
        if (oq_push)
        begin
            oq_reg[oq_wptr_reg] <= res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            oq_wptr_reg  <= '0;
            oq_rptr_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= snap_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (oq_push)
            begin
                oq_wptr_reg <= oq_wptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rptr_reg <= oq_rptr_reg + 1'b1;
            end
            oq_count_reg <= oq_count_reg + (Q_AW+1)'(oq_push) - (Q_AW+1)'(oq_pop);
        end
    end

    // Truncation toward zero of val + b/7 (left) or val - b/7 (right): the
    // rounded quotient is corrected by one when the division leaves a remainder
    // and the whole numerator is negative (left) or positive (right).
    always_comb
    begin
        q7     = B_W'({b_q_reg, 3'b000}) - B_W'(b_q_reg);
        rem_nz = (b_b_reg != q7);
        b_s    = $signed({{(EW-B_W){1'b0}}, b_b_reg});
        q_s    = $signed({{(EW-Q_W){1'b0}}, b_q_reg});
        a7     = K7 * b_val_reg;

        case (b_mode_reg)
            CORR_LEFT:
            begin
                res = b_val_reg + q_s;
                if (rem_nz && (a7 + b_s < 0))
                begin
                    res = res + EW'(1);
                end
            end
            CORR_RIGHT:
            begin
                res = b_val_reg - q_s;
                if (rem_nz && (a7 > b_s))
                begin
                    res = res - EW'(1);
                end
            end
            default:
            begin
                res = b_val_reg;
            end
        endcase

        if (res > SAT_MAX)
        begin
            sat = SAT_MAX;
        end
        else if (res < SAT_MIN)
        begin
            sat = SAT_MIN;
        end
        else
        begin
            sat = res;
        end

        res_item.steer_error = sat[15:0];
        res_item.wall_ahead  = b_flags_reg[2];
        res_item.wall_right  = b_flags_reg[1];
        res_item.wall_left   = b_flags_reg[0];
    end

    assign result = oq_reg[oq_rptr_reg];

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the wall-follow error unit
// Directed and random sensor items are sent through the input queue under
// bursty traffic and receiver stalls. Each result is compared field by field
// with a prediction kept from a local copy of the readings and registers.
// ----------------------------------------------------------------------------
module tb_top;
    import wfe_pkg::*;

    localparam logic KIND_COMPUTE   = 1'b1;
    localparam int   CYCLE_LIMIT    = 400000;
    localparam int   DRAIN_CYCLES   = 4;
    localparam int   RANDOM_PHASES  = 6;
    localparam int   PHASE_ITEMS    = 250;
    localparam int   BURST_ITEMS    = 40;
    localparam int   HOLD_CYCLES    = 400;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                push        = 1'b0;
    logic                full;
    sample_t             sample_item = '0;
    logic                empty;
    logic                pop         = 1'b0;
    result_t             result_item;
    logic                cfg_write   = 1'b0;
    logic [2:0]          cfg_index   = CFG_SIDE_REFS;
    logic [CFG_BITS-1:0] cfg_data    = '0;

    // Local copy of the block's readings and registers.
    logic [SAMPLE_BITS-1:0] reading_now  [4];
    logic [SAMPLE_BITS-1:0] reading_last [4];
    cfg_t                   model_cfg;

    result_t pending_results [$];

    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int hold_request    = 0;
    int hold_left       = 0;
    int stall_pct       = 0;
    int window_left     = 0;

    wall_follow_error_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample_item),
        .empty     (empty),
        .pop       (pop),
        .result    (result_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            reading_now[i]  = '0;
            reading_last[i] = '0;
        end
        model_cfg = '0;
    end

    function automatic logic [CFG_BITS-1:0] pack_lr(input int left_val, input int right_val);
        return {12'(left_val), 12'(right_val)};
    endfunction

    function automatic int edge_threshold(input int now_val, input int last_val,
                                          input int ref_val, input int lim_val);
        int step;
        int f;
        step = now_val - last_val;
        f    = int'(model_cfg.edge_step_limit);
        if (step < -f || step > f)
            return ref_val + int'(model_cfg.edge_ref_margin);
        return lim_val;
    endfunction

    // Updates the local readings with one item and returns its expected result.
    function automatic result_t predict_steer(input sample_t s);
        int      rf, lf, rs, ls;
        int      rs_ref, ls_ref, rs_lim, ls_lim;
        int      rf_ref, lf_ref, rf_lim, lf_lim;
        int      th_r, th_l, err;
        bit      wall_r, wall_l;
        result_t r;
        if (s.kind == KIND_SAMPLE)
        begin
            reading_last[s.sensor] = reading_now[s.sensor];
            reading_now[s.sensor]  = (s.lit_sample >= s.dark_sample) ?
                                     s.lit_sample - s.dark_sample : '0;
        end
        rf     = int'(reading_now[SENSOR_RF]);
        lf     = int'(reading_now[SENSOR_LF]);
        rs     = int'(reading_now[SENSOR_RS]);
        ls     = int'(reading_now[SENSOR_LS]);
        rs_ref = int'(model_cfg.side_refs[11:0]);
        ls_ref = int'(model_cfg.side_refs[23:12]);
        rs_lim = int'(model_cfg.side_limits[11:0]);
        ls_lim = int'(model_cfg.side_limits[23:12]);
        rf_ref = int'(model_cfg.front_refs[11:0]);
        lf_ref = int'(model_cfg.front_refs[23:12]);
        rf_lim = int'(model_cfg.front_limits[11:0]);
        lf_lim = int'(model_cfg.front_limits[23:12]);

        th_r   = edge_threshold(rs, int'(reading_last[SENSOR_RS]), rs_ref, rs_lim);
        th_l   = edge_threshold(ls, int'(reading_last[SENSOR_LS]), ls_ref, ls_lim);
        wall_r = th_r < rs;
        wall_l = th_l < ls;

        err = 0;
        if (rf > int'(model_cfg.front_noctrl_levels[11:0]) &&
            lf > int'(model_cfg.front_noctrl_levels[23:12]))
            err = 0;
        else if (rf > int'(model_cfg.front_ctrl_levels[11:0]) &&
                 lf > int'(model_cfg.front_ctrl_levels[23:12]))
            err = (lf - lf_ref) - (rf - rf_ref);
        else if (wall_r && wall_l)
            err = (rs - rs_ref) + (ls_ref - ls);
        else if (wall_r)
            err = (rs - rs_ref) * 2;
        else if (wall_l)
            err = (ls_ref - ls) * 2;

        // The front correction uses limit / 0.7 exactly; the divide truncates toward zero.
        if (7 * lf > 10 * lf_lim && 7 * rf < 10 * rf_lim)
            err = (7 * err + 2 * (10 * lf_lim - 7 * lf)) / 7;
        else if (7 * rf > 10 * rf_lim && 7 * lf < 10 * lf_lim)
            err = (7 * err + 2 * (7 * rf - 10 * rf_lim)) / 7;

        if (err > 32767)
            err = 32767;
        if (err < -32768)
            err = -32768;

        r.steer_error = 16'(err);
        r.wall_ahead  = (rf > rf_lim) || (lf > lf_lim);
        r.wall_right  = rs > rs_lim;
        r.wall_left   = ls > ls_lim;
        return r;
    endfunction

    // Leaves push high on return so that the next item can follow directly.
    task automatic send_sample(input sample_t s);
        push        <= 1'b1;
        sample_item <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(predict_steer(s));
        items_sent++;
    endtask

    task automatic pause(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_in_bursts(input sample_t s);
        send_sample(s);
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_SIDE_REFS:    model_cfg.side_refs           = value;
            CFG_SIDE_LIMITS:  model_cfg.side_limits         = value;
            CFG_FRONT_REFS:   model_cfg.front_refs          = value;
            CFG_FRONT_LIMITS: model_cfg.front_limits        = value;
            CFG_FRONT_CTRL:   model_cfg.front_ctrl_levels   = value;
            CFG_FRONT_NOCTRL: model_cfg.front_noctrl_levels = value;
            CFG_EDGE_STEP:    model_cfg.edge_step_limit     = value[11:0];
            CFG_EDGE_MARGIN:  model_cfg.edge_ref_margin     = value[11:0];
            default: ;
        endcase
    endtask

    // The edge registers are 12 bits wide; the upper data bits carry noise.
    task automatic set_config(input cfg_t c);
        drain();
        write_reg(CFG_SIDE_REFS,    c.side_refs);
        write_reg(CFG_SIDE_LIMITS,  c.side_limits);
        write_reg(CFG_FRONT_REFS,   c.front_refs);
        write_reg(CFG_FRONT_LIMITS, c.front_limits);
        write_reg(CFG_FRONT_CTRL,   c.front_ctrl_levels);
        write_reg(CFG_FRONT_NOCTRL, c.front_noctrl_levels);
        write_reg(CFG_EDGE_STEP,    {12'($urandom), c.edge_step_limit});
        write_reg(CFG_EDGE_MARGIN,  {12'($urandom), c.edge_ref_margin});
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    function automatic sample_t make_sample(input logic [1:0] sensor, input int lit_val,
                                            input int dark_val);
        sample_t s;
        s.kind        = KIND_SAMPLE;
        s.sensor      = sensor;
        s.lit_sample  = 12'(lit_val);
        s.dark_sample = 12'(dark_val);
        return s;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.kind        = ($urandom_range(0, 9) == 0) ? KIND_COMPUTE : KIND_SAMPLE;
        s.sensor      = 2'($urandom_range(0, 3));
        s.lit_sample  = 12'($urandom_range(0, 4095));
        s.dark_sample = ($urandom_range(0, 3) == 0) ? 12'($urandom) :
                                                     12'($urandom_range(0, 300));
        return s;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.side_refs           = 24'($urandom);
        c.side_limits         = 24'($urandom);
        c.front_refs          = 24'($urandom);
        c.front_limits        = pack_lr($urandom_range(0, 3000), $urandom_range(0, 3000));
        c.front_ctrl_levels   = pack_lr($urandom_range(0, 2500), $urandom_range(0, 2500));
        c.front_noctrl_levels = 24'($urandom);
        c.edge_step_limit     = 12'($urandom_range(0, 1500));
        c.edge_ref_margin     = 12'($urandom);
        return c;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result with no item waiting: steer_error %0d", got.steer_error);
            error_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.steer_error !== want.steer_error)
            begin
                $error("steer_error: expected %0d, actual %0d",
                       want.steer_error, got.steer_error);
                error_count++;
            end
            if (got.wall_ahead !== want.wall_ahead)
            begin
                $error("wall_ahead: expected %0b, actual %0b", want.wall_ahead, got.wall_ahead);
                error_count++;
            end
            if (got.wall_right !== want.wall_right)
            begin
                $error("wall_right: expected %0b, actual %0b", want.wall_right, got.wall_right);
                error_count++;
            end
            if (got.wall_left !== want.wall_left)
            begin
                $error("wall_left: expected %0b, actual %0b", want.wall_left, got.wall_left);
                error_count++;
            end
        end
    endtask

    // Result side: checks every accepted item and stalls in windows of varying
    // density, or for a long stretch when a hold is requested.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_result(result_item);
        if (window_left <= 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            window_left = $urandom_range(16, 96);
        end
        window_left--;
        if (hold_left == 0 && hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_sample_extremes();
        cfg_t    c;
        sample_t s;
        c.side_refs           = pack_lr(2000, 2000);
        c.side_limits         = pack_lr(1000, 1000);
        c.front_refs          = pack_lr(1500, 1500);
        c.front_limits        = pack_lr(800, 800);
        c.front_ctrl_levels   = pack_lr(1200, 1200);
        c.front_noctrl_levels = pack_lr(3000, 3000);
        c.edge_step_limit     = 12'd400;
        c.edge_ref_margin     = 12'd100;
        set_config(c);
        send_sample(make_sample(SENSOR_RF, 4095, 0));
        // A lit reading below the dark one stores zero.
        send_sample(make_sample(SENSOR_LF, 0, 4095));
        send_sample(make_sample(SENSOR_RS, 2000, 2000));
        send_sample(make_sample(SENSOR_LS, 4095, 0));
        // A compute-only item ignores its sensor and sample fields.
        s        = '1;
        s.kind   = KIND_COMPUTE;
        send_sample(s);
        send_sample(make_sample(SENSOR_RF, 0, 0));
    endtask

    task automatic test_front_priority();
        send_sample(make_sample(SENSOR_RF, 2000, 0));
        send_sample(make_sample(SENSOR_LF, 2300, 100));
        // Both fronts too close: control switches off.
        send_sample(make_sample(SENSOR_RF, 3500, 0));
        send_sample(make_sample(SENSOR_LF, 3600, 0));
        send_sample(make_sample(SENSOR_LF, 100, 0));
    endtask

    task automatic test_side_walls();
        cfg_t c;
        c                     = model_cfg;
        c.side_refs           = pack_lr(1500, 1500);
        c.front_limits        = pack_lr(4095, 4095);
        c.edge_step_limit     = 12'd500;
        c.edge_ref_margin     = 12'd200;
        set_config(c);
        send_sample(make_sample(SENSOR_RF, 0, 0));
        send_sample(make_sample(SENSOR_LF, 0, 0));
        // A large step moves the side threshold to reference plus margin.
        send_sample(make_sample(SENSOR_RS, 1200, 0));
        send_sample(make_sample(SENSOR_RS, 1200, 0));
        send_sample(make_sample(SENSOR_LS, 1300, 0));
        send_sample(make_sample(SENSOR_LS, 1300, 0));
        send_sample(make_sample(SENSOR_RS, 100, 0));
        send_sample(make_sample(SENSOR_RS, 100, 0));
    endtask

    task automatic test_front_correction();
        cfg_t c;
        c              = model_cfg;
        c.front_limits = pack_lr(1000, 1000);
        set_config(c);
        send_sample(make_sample(SENSOR_LF, 2000, 0));
        send_sample(make_sample(SENSOR_RF, 100, 0));
        send_sample(make_sample(SENSOR_LF, 100, 0));
        send_sample(make_sample(SENSOR_RF, 2000, 0));
    endtask

    task automatic test_random_traffic();
        cfg_t c;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                c = '0;
            else if (phase == 1)
                c = '1;
            else
                c = random_cfg();
            set_config(c);
            burst_left = $urandom_range(1, 24);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_in_bursts(random_sample());
        end
    endtask

    // The receiver holds off while items keep coming, so the block fills up.
    task automatic test_backpressure();
        set_config(random_cfg());
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < BURST_ITEMS; i++)
            send_sample(random_sample());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_sample_extremes();
        test_front_priority();
        test_side_walls();
        test_front_correction();
        test_random_traffic();
        test_backpressure();
        drain();
        $display("Sent %0d items over %0d register settings; %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("Traffic included bursts, receiver stalls and one long hold-off.");
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
